// ===== design/polarized_map_binning_accumulator_core_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the polarized map binning accumulator
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef POLARIZED_MAP_BINNING_ACCUMULATOR_CORE_DEFINES_SVH
`define POLARIZED_MAP_BINNING_ACCUMULATOR_CORE_DEFINES_SVH

`ifndef SYNTH

// Clocked check, muted while reset is held
`define PMBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked check that also holds during reset
`define PMBA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define PMBA_ASSERT(lbl, prop, msg)
`define PMBA_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ===== design/pmba_pkg.sv =====
// ----------------------------------------------------------------------------
// pmba_pkg
// Widths, codes, queue request type and saturating add for the map binner.
// ----------------------------------------------------------------------------
package pmba_pkg;

  localparam int PIX_W      = 12;
  localparam int NUM_PIXELS = 4096;
  localparam int ACC_W      = 48;
  localparam int SAMPLE_W   = 32;
  localparam int TRIG_W     = 16;
  localparam int PROD_W     = SAMPLE_W + TRIG_W;
  localparam int FRAC_BITS  = 15;
  localparam int MODE_W     = 2;
  localparam int COMP_W     = 2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Action codes
  localparam logic ACT_ACC  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  // Stokes mode codes
  localparam logic [MODE_W-1:0] MODE_I   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_QU  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_IQU = 2'd2;

  // Bank select codes
  localparam logic [COMP_W-1:0] COMP_I = 2'd0;
  localparam logic [COMP_W-1:0] COMP_Q = 2'd1;
  localparam logic [COMP_W-1:0] COMP_U = 2'd2;

  // One classified request between front and back
  typedef struct packed {
    logic                    is_read;
    logic                    in_range;
    logic [COMP_W-1:0]       comp;
    logic [PIX_W-1:0]        pixel;
    logic                    en_i;
    logic                    en_qu;
    logic signed [ACC_W-1:0] add_i;
    logic signed [ACC_W-1:0] add_q;
    logic signed [ACC_W-1:0] add_u;
  } cmd_t;

  // Back-end status seen by the front
  typedef struct packed {
    logic clearing;
  } back_status_t;

  // Two's complement add that clamps at the accumulator limits
  function automatic logic signed [ACC_W-1:0] sat_add(
    input logic signed [ACC_W-1:0] acc,
    input logic signed [ACC_W-1:0] add
  );
    logic signed [ACC_W:0] sum;
    sum = {acc[ACC_W-1], acc} + {add[ACC_W-1], add};
    if (sum[ACC_W] != sum[ACC_W-1]) begin
      if (sum[ACC_W]) return {1'b1, {(ACC_W-1){1'b0}}};
      else return {1'b0, {(ACC_W-1){1'b1}}};
    end
    return sum[ACC_W-1:0];
  endfunction

endpackage

// ===== design/pmba_front.sv =====
// ----------------------------------------------------------------------------
// pmba_front
// Accepts items, holds the mode register, forms the weighted addends and
// pushes reads and effective accumulates into the request queue.
// ----------------------------------------------------------------------------
module pmba_front import pmba_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [MODE_W-1:0]          cfg_stokes_mode,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_action,
  input  logic [PIX_W-1:0]           in_pixel,
  input  logic                       in_sample_flag,
  input  logic signed [SAMPLE_W-1:0] in_sample_value,
  input  logic signed [TRIG_W-1:0]   in_cos_term,
  input  logic signed [TRIG_W-1:0]   in_sin_term,
  input  logic [COMP_W-1:0]          in_component,
  // queue side
  input  logic                       q_full,
  input  back_status_t               back_status,
  output logic                       q_push,
  output cmd_t                       q_push_data
);

  logic [MODE_W-1:0]        stokes_mode_r;
  logic [MODE_W-1:0]        stokes_mode_nxt;
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] prod_u;
  logic                     in_range;
  logic                     en_i;
  logic                     en_qu;
  logic                     accept;

  // Mode register, always writable
  assign cfg_ready = 1'b1;
  assign stokes_mode_nxt = (cfg_valid && cfg_ready) ? cfg_stokes_mode : stokes_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stokes_mode_r <= MODE_IQU;
    end else begin
      stokes_mode_r <= stokes_mode_nxt;
    end
  end

  // Hold off while the banks are being cleared or the queue is full
  assign in_stall = q_full || back_status.clearing;
  assign accept   = in_valid && !in_stall;

  // Classification
  assign in_range = ({1'b0, in_pixel} < (PIX_W + 1)'(NUM_PIXELS));
  assign en_i     = (stokes_mode_r == MODE_I)  || (stokes_mode_r == MODE_IQU);
  assign en_qu    = (stokes_mode_r == MODE_QU) || (stokes_mode_r == MODE_IQU);

  // Q1.15 weighting, registered by the queue storage
  assign prod_q = in_sample_value * in_cos_term;
  assign prod_u = in_sample_value * in_sin_term;

  always_comb begin
    q_push_data.is_read  = (in_action == ACT_READ);
    q_push_data.in_range = in_range;
    q_push_data.comp     = in_component;
    q_push_data.pixel    = in_pixel;
    q_push_data.en_i     = en_i;
    q_push_data.en_qu    = en_qu;
    q_push_data.add_i    = ACC_W'(in_sample_value);
    q_push_data.add_q    = ACC_W'(prod_q >>> FRAC_BITS);
    q_push_data.add_u    = ACC_W'(prod_u >>> FRAC_BITS);
  end

  // Accumulates with no effect are dropped here
  assign q_push = accept &&
                  ((in_action == ACT_READ) ||
                   (in_sample_flag && in_range && (en_i || en_qu)));

endmodule

// ===== design/pmba_fifo.sv =====
// ----------------------------------------------------------------------------
// pmba_fifo
// Short request queue decoupling the front from the bank update engine.
// ----------------------------------------------------------------------------
module pmba_fifo import pmba_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_data,
  input  logic pop,
  output cmd_t head,
  output logic not_empty,
  output logic full
);

  cmd_t              store_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;
  logic              do_push;
  logic              do_pop;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = store_r[rd_ptr_r];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      store_r[wr_ptr_r] <= push_data;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (do_pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      if (do_push && !do_pop) count_r <= count_r + QCNT_W'(1);
      else if (do_pop && !do_push) count_r <= count_r - QCNT_W'(1);
    end
  end

endmodule

// ===== design/pmba_back.sv =====
// ----------------------------------------------------------------------------
// pmba_back
// Bank engine: clears the I, Q and U banks after reset, then runs one queued
// request at a time as a bank read, then a saturating write back or a result.
// ----------------------------------------------------------------------------
`include "polarized_map_binning_accumulator_core_defines.svh"

module pmba_back import pmba_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  // queue side
  input  logic                    q_not_empty,
  input  cmd_t                    q_head,
  output logic                    pop,
  output back_status_t            status,
  // result channel
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [ACC_W-1:0] out_read_data
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UPDATE
  } state_t;

  state_t                  state_r;
  state_t                  state_nxt;
  logic [PIX_W-1:0]        clr_cnt_r;
  logic [PIX_W-1:0]        clr_cnt_nxt;
  cmd_t                    cmd_r;
  cmd_t                    cmd_nxt;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic signed [ACC_W-1:0] out_data_r;
  logic signed [ACC_W-1:0] out_data_nxt;

  logic signed [ACC_W-1:0] bank_i [NUM_PIXELS];
  logic signed [ACC_W-1:0] bank_q [NUM_PIXELS];
  logic signed [ACC_W-1:0] bank_u [NUM_PIXELS];
  logic signed [ACC_W-1:0] rd_i_r;
  logic signed [ACC_W-1:0] rd_q_r;
  logic signed [ACC_W-1:0] rd_u_r;

  logic                    wr_en_i;
  logic                    wr_en_qu;
  logic [PIX_W-1:0]        wr_addr;
  logic signed [ACC_W-1:0] wr_i;
  logic signed [ACC_W-1:0] wr_q;
  logic signed [ACC_W-1:0] wr_u;
  logic signed [ACC_W-1:0] rd_sel;

  assign pop             = (state_r == ST_IDLE) && q_not_empty;
  assign status.clearing = (state_r == ST_CLEAR);
  assign out_valid       = out_valid_r;
  assign out_read_data   = out_data_r;

  // Bank port control: zero sweep during clear, write back on update
  always_comb begin
    wr_en_i  = 1'b0;
    wr_en_qu = 1'b0;
    wr_addr  = cmd_r.pixel;
    wr_i     = sat_add(rd_i_r, cmd_r.add_i);
    wr_q     = sat_add(rd_q_r, cmd_r.add_q);
    wr_u     = sat_add(rd_u_r, cmd_r.add_u);
    case (state_r)
      ST_CLEAR: begin
        wr_en_i  = 1'b1;
        wr_en_qu = 1'b1;
        wr_addr  = clr_cnt_r;
        wr_i     = '0;
        wr_q     = '0;
        wr_u     = '0;
      end
      ST_UPDATE: begin
        wr_en_i  = !cmd_r.is_read && cmd_r.en_i;
        wr_en_qu = !cmd_r.is_read && cmd_r.en_qu;
      end
      default: begin
        wr_en_i  = 1'b0;
        wr_en_qu = 1'b0;
      end
    endcase
  end

  // Banks: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en_i) bank_i[wr_addr] <= wr_i;
    if (wr_en_qu) begin
      bank_q[wr_addr] <= wr_q;
      bank_u[wr_addr] <= wr_u;
    end
    if (pop) begin
      rd_i_r <= bank_i[q_head.pixel];
      rd_q_r <= bank_q[q_head.pixel];
      rd_u_r <= bank_u[q_head.pixel];
    end
  end

  // Read result select
  always_comb begin
    case (cmd_r.comp)
      COMP_I:  rd_sel = rd_i_r;
      COMP_Q:  rd_sel = rd_q_r;
      COMP_U:  rd_sel = rd_u_r;
      default: rd_sel = '0;
    endcase
    if (!cmd_r.in_range) rd_sel = '0;
  end

  // Sequencer next state
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    cmd_nxt       = cmd_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + PIX_W'(1);
        if (clr_cnt_r == PIX_W'(NUM_PIXELS - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (pop) begin
          cmd_nxt   = q_head;
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!cmd_r.is_read) begin
          state_nxt = ST_IDLE;
        end else if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = rd_sel;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    out_data_r <= out_data_nxt;
  end

  // Checks
  `PMBA_ASSERT(a_no_pop_in_clear, (state_r == ST_CLEAR) |-> !pop, "request popped during clear")
  `PMBA_ASSERT(a_out_from_read, $rose(out_valid_r) |-> $past(state_r == ST_UPDATE && cmd_r.is_read), "result without a read request")
  `PMBA_ASSERT(a_write_window, (wr_en_i || wr_en_qu) |-> (state_r == ST_CLEAR || (state_r == ST_UPDATE && !cmd_r.is_read)), "bank write outside clear or update")

endmodule

// ===== design/polarized_map_binning_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// polarized_map_binning_accumulator_core
// Scatter-adds weighted samples into I, Q and U map banks and reads entries.
// ----------------------------------------------------------------------------
// Reads: an accepted read goes through the queue, a registered bank read and
// the result register; a stalled result holds the engine.
// Items: one queued item at a time through the bank read/update/write
// sequence; items with no effect skip the queue.
// Reset: synchronous; clears the mode to IQU, then sweeps the banks to zero
// over every pixel with in_stall held high.
module polarized_map_binning_accumulator_core import pmba_pkg::*; (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [MODE_W-1:0]          cfg_stokes_mode,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_action,
  input  logic [PIX_W-1:0]           in_pixel,
  input  logic                       in_sample_flag,
  input  logic signed [SAMPLE_W-1:0] in_sample_value,
  input  logic signed [TRIG_W-1:0]   in_cos_term,
  input  logic signed [TRIG_W-1:0]   in_sin_term,
  input  logic [COMP_W-1:0]          in_component,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [ACC_W-1:0]    out_read_data
);

  logic         q_push;
  cmd_t         q_push_data;
  logic         q_pop;
  cmd_t         q_head;
  logic         q_not_empty;
  logic         q_full;
  back_status_t back_status;

  // Front: mode register, classification, weighting
  pmba_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_stokes_mode (cfg_stokes_mode),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_pixel        (in_pixel),
    .in_sample_flag  (in_sample_flag),
    .in_sample_value (in_sample_value),
    .in_cos_term     (in_cos_term),
    .in_sin_term     (in_sin_term),
    .in_component    (in_component),
    .q_full          (q_full),
    .back_status     (back_status),
    .q_push          (q_push),
    .q_push_data     (q_push_data)
  );

  // Request queue
  pmba_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  // Bank engine and result register
  pmba_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_not_empty   (q_not_empty),
    .q_head        (q_head),
    .pop           (q_pop),
    .status        (back_status),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_data (out_read_data)
  );

endmodule
